// ===== design/bud_pkg.sv =====
// Package for the backslash unescape decoder.
// Holds shared constants, the character set codes, the decode result struct
// and the set membership function. It depends on nothing.
package bud_pkg;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] DOLLAR    = 8'h24;
	localparam logic [7:0] CHR_N     = 8'h6E;
	localparam logic [7:0] CHR_T     = 8'h74;
	localparam logic [7:0] CHR_B     = 8'h62;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CTL_LF    = 8'h0A;
	localparam logic [7:0] CTL_TAB   = 8'h09;
	localparam logic [7:0] CTL_BS    = 8'h08;
	localparam logic [7:0] CTL_NUL   = 8'h00;

	localparam logic REG_CHAR_SET = 1'b0;
	localparam logic REG_MAP_NP   = 1'b1;

	localparam logic [1:0] CHAR_SET_RESET = 2'd0;
	localparam logic       MAP_NP_RESET   = 1'b1;

	typedef enum logic [1:0] {
		SET_SHELL = 2'd0,
		SET_GLOB  = 2'd1,
		SET_REGEX = 2'd2
	} char_set_t;

	typedef struct packed {
		logic       none;
		logic       two;
		logic       set_pending;
		logic [7:0] byte0;
		logic       last0;
		logic [7:0] byte1;
		logic       last1;
	} dec_t;

	function automatic logic is_member(input logic [7:0] b, input logic [1:0] set);
		logic hit;
		hit = 1'b0;
		case (set)
			SET_SHELL: begin
				case (b) inside
					8'h00, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
					8'h28, 8'h29, 8'h2A, 8'h3B, 8'h3C, 8'h3E, 8'h3F, 8'h5B, 8'h5C,
					8'h5D, 8'h60, 8'h7B, 8'h7C, 8'h7D: hit = 1'b1;
					default: hit = 1'b0;
				endcase
			end
			SET_GLOB: begin
				case (b) inside
					8'h00, 8'h24, 8'h2A, 8'h3F, 8'h5C: hit = 1'b1;
					default: hit = 1'b0;
				endcase
			end
			default: begin
				case (b) inside
					8'h00, 8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2A,
					8'h2B, 8'h2E, 8'h3B, 8'h3C, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D,
					8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D: hit = 1'b1;
					default: hit = 1'b0;
				endcase
			end
		endcase
		return hit;
	endfunction

endpackage

// ===== design/bud_decode.sv =====
// Combinational escape decoder for one registered input item.
// Uses bud_pkg for the constants, the membership function and dec_t.
module bud_decode (
	input  logic              pending,
	input  logic [1:0]        char_set,
	input  logic              map_np,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output bud_pkg::dec_t     dec
);

	always_comb begin
		dec             = '0;
		dec.byte0       = in_byte;
		dec.last0       = in_last;
		dec.byte1       = in_byte;
		dec.last1       = in_last;
		if (pending) begin
			if (char_set == bud_pkg::SET_SHELL && in_byte == bud_pkg::DOLLAR) begin
				dec.two   = 1'b1;
				dec.byte0 = bud_pkg::BACKSLASH;
				dec.last0 = 1'b0;
			end else if (map_np && in_byte == bud_pkg::CHR_N) begin
				dec.byte0 = bud_pkg::CTL_LF;
			end else if (map_np && in_byte == bud_pkg::CHR_T) begin
				dec.byte0 = bud_pkg::CTL_TAB;
			end else if (map_np && in_byte == bud_pkg::CHR_B) begin
				dec.byte0 = bud_pkg::CTL_BS;
			end else if (map_np && in_byte == bud_pkg::CHR_ZERO) begin
				dec.byte0 = bud_pkg::CTL_NUL;
			end else if (!bud_pkg::is_member(in_byte, char_set)) begin
				dec.two   = 1'b1;
				dec.byte0 = bud_pkg::BACKSLASH;
				dec.last0 = 1'b0;
			end
		end else if (in_byte == bud_pkg::BACKSLASH && !in_last) begin
			dec.none        = 1'b1;
			dec.set_pending = 1'b1;
		end
	end

endmodule

// ===== design/bud_out_buf.sv =====
// Output register pair that holds the one or two bytes of a decoded item.
// Uses bud_pkg for dec_t; drives the master side of the stream.
module bud_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bud_pkg::dec_t     dec,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);

	logic       valid_q;
	logic       two_q;
	logic [7:0] byte0_q;
	logic       last0_q;
	logic [7:0] byte1_q;
	logic       last1_q;

	assign free     = !valid_q || (m_tready && !two_q);
	assign m_tvalid = valid_q;
	assign m_tdata  = byte0_q;
	assign m_tlast  = last0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			two_q   <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
			two_q   <= dec.two;
		end else if (valid_q && m_tready) begin
			valid_q <= two_q;
			two_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			byte0_q <= dec.byte0;
			last0_q <= dec.last0;
			byte1_q <= dec.byte1;
			last1_q <= dec.last1;
		end else if (valid_q && m_tready && two_q) begin
			byte0_q <= byte1_q;
			last0_q <= last1_q;
		end
	end

	a_two_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		two_q |-> valid_q) else $error("second byte held without a first");

	a_first_of_two_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		two_q |-> !last0_q) else $error("first of two bytes marked last");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && two_q && m_tready && !push |=> valid_q && !two_q)
		else $error("second byte lost after first was taken");

endmodule

// ===== design/backslash_unescape_decoder_core.sv =====
// Top level of the backslash unescape decoder.
// Instantiates bud_decode and bud_out_buf; uses bud_pkg.
//
// Usage: escaped bytes arrive on the s_ side, one byte per item in s_tdata,
// with s_tlast on the final byte of a string. Unescaped bytes leave on the
// m_ side, with m_tlast on the final byte of the decoded string. An item is
// taken at a clock edge where tvalid and tready are both high.
// An accepted item is held in an input register, decoded, and loaded into the
// output register pair, from which its first byte is offered on the m_ side.
// One item is accepted per cycle while the output pair can take it; an item
// that yields two bytes (a backslash kept before its byte) holds the output
// pair until its second byte is taken. A backslash that opens an escape
// yields no byte. The configuration port (cfg_we, cfg_index, cfg_data)
// writes char_set at index 0 and map_nonprintable at index 1; the user must
// write it only while idle, which the block does not enforce. Reset clears
// the pipeline and the pending backslash and sets char_set to the shell set
// and the non-printable mapping on. When the receiver stalls, the output pair
// and the input register fill and s_tready drops.
module backslash_unescape_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte [7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte [7:0]
	output logic        m_tlast
);

	logic [1:0]     char_set_q;
	logic           map_np_q;
	logic           pending_q;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic           out_free;
	logic           move_s1;
	logic           push;
	bud_pkg::dec_t  dec;

	assign move_s1  = valid_s1 && (dec.none || out_free);
	assign push     = valid_s1 && !dec.none && out_free;
	assign s_tready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_set_q <= bud_pkg::CHAR_SET_RESET;
			map_np_q   <= bud_pkg::MAP_NP_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bud_pkg::REG_CHAR_SET) begin
				char_set_q <= cfg_data;
			end else if (cfg_index == bud_pkg::REG_MAP_NP) begin
				map_np_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (move_s1) begin
				pending_q <= dec.set_pending;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	bud_decode u_decode (
		.pending  (pending_q),
		.char_set (char_set_q),
		.map_np   (map_np_q),
		.in_byte  (byte_s1),
		.in_last  (last_s1),
		.dec      (dec)
	);

	bud_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.dec      (dec),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_pending_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q && move_s1 |=> !pending_q) else $error("escape left pending");

	a_escape_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && dec.set_pending |-> !push) else $error("opening backslash emitted");

	a_pending_only_from_bs: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_q) |-> $past(byte_s1) == bud_pkg::BACKSLASH)
		else $error("pending state corrupted");

endmodule
